// ===== hdl/framed_command_receiver_top_defines.svh =====
// ----------------------------------------------------------------------------
// Framed command receiver assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FRAMED_COMMAND_RECEIVER_TOP_DEFINES_SVH
`define FRAMED_COMMAND_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication.
`define FCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Framed command receiver package
// Shared constants, codes and types of the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fcr_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int PAY_AW      = $clog2(MAX_PAYLOAD);
  localparam int CNT_W       = 6;
  localparam int POS_W       = 5;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  localparam logic [CNT_W-1:0] MAX_PAYLOAD_C = CNT_W'(MAX_PAYLOAD);

  localparam logic [7:0]       START_BYTE_RST    = 8'h00;
  localparam logic [7:0]       CHECK_SEED_RST    = 8'h55;
  localparam logic [CNT_W-1:0] PAYLOAD_LIMIT_RST = 6'd32;

  typedef enum logic [1:0] {
    REG_START_BYTE    = 2'd0,
    REG_CHECK_SEED    = 2'd1,
    REG_PAYLOAD_LIMIT = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_BUSY    = 2'd2,
    OP_RXERR   = 2'd3
  } op_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_LENGTH  = 3'd1;
  localparam logic [2:0] ST_CHECK   = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_BUSY    = 3'd4;
  localparam logic [2:0] ST_RXERR   = 3'd5;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT      = 3'd0,
    PH_CMD       = 3'd1,
    PH_LEN       = 3'd2,
    PH_DATA      = 3'd3,
    PH_CHECK     = 3'd4,
    PH_DRAIN_RD  = 3'd5,
    PH_DRAIN_OUT = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0]       start_byte;
    logic [7:0]       check_seed;
    logic [CNT_W-1:0] payload_limit;
  } cfg_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       command;
    logic [7:0]       frame_length;
    logic [POS_W-1:0] position;
    logic [7:0]       payload_byte;
    logic [2:0]       status;
    logic             last;
  } result_t;

  function automatic logic [2:0] line_status(input logic [1:0] op);
    logic [2:0] st;
    case (op)
      OP_TIMEOUT: st = ST_TIMEOUT;
      OP_BUSY:    st = ST_BUSY;
      default:    st = ST_RXERR;
    endcase
    return st;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/framed_command_receiver_top.sv =====
// ----------------------------------------------------------------------------
// Framed command receiver
// Start-byte framed command parser with seeded XOR check and payload buffer.
//
//   Channel  Direction  Handshake                 Payload
//   in_      in         in_valid / in_stall       in_op, in_data
//   out_     out        out_valid / out_stall     kind, command, frame_length,
//                                                 position, payload_byte,
//                                                 status, last
//   cfg      in/out     psel, penable, pready     paddr, pwdata, prdata
//
// A received byte or line event is taken while the parser is not draining
// a frame and the result register is free to load.
// A good frame drains each payload byte by a store read in PH_DRAIN_RD and a
// result load in PH_DRAIN_OUT, then loads the final status.
// in_stall is high while a frame drains and while a held result is stalled.
// The payload store has no clearing pass; only entries of the current frame
// are read.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_command_receiver_top
  import fcr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_op,
  input  wire logic [7:0]        in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_kind,
  output logic      [7:0]        out_command,
  output logic      [7:0]        out_frame_length,
  output logic      [POS_W-1:0]  out_position,
  output logic      [7:0]        out_payload_byte,
  output logic      [2:0]        out_status,
  output logic                   out_last,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t              cfg;
  result_t           res;
  logic              ram_we;
  logic [PAY_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [PAY_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  fcr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fcr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .in_data   (in_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_kind         = res.kind;
  assign out_command      = res.command;
  assign out_frame_length = res.frame_length;
  assign out_position     = res.position;
  assign out_payload_byte = res.payload_byte;
  assign out_status       = res.status;
  assign out_last         = res.last;

endmodule

`default_nettype wire

// ===== hdl/fcr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered on read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/fcr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Framed command receiver configuration registers
// APB-style register file for start byte, check seed and payload limit.
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_cfg_regs
  import fcr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_START_BYTE:    cfg_nxt.start_byte    = pwdata[7:0];
        REG_CHECK_SEED:    cfg_nxt.check_seed    = pwdata[7:0];
        REG_PAYLOAD_LIMIT: cfg_nxt.payload_limit = pwdata[CNT_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte    <= START_BYTE_RST;
      cfg_r.check_seed    <= CHECK_SEED_RST;
      cfg_r.payload_limit <= PAYLOAD_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_START_BYTE:    prdata = {{(CFG_DW-8){1'b0}}, cfg_r.start_byte};
      REG_CHECK_SEED:    prdata = {{(CFG_DW-8){1'b0}}, cfg_r.check_seed};
      REG_PAYLOAD_LIMIT: prdata = {{(CFG_DW-CNT_W){1'b0}}, cfg_r.payload_limit};
      default:           prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hdl/fcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Framed command receiver controller
// Frame parser state machine, payload store access and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "framed_command_receiver_top_defines.svh"

module fcr_ctrl
  import fcr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_op,
  input  wire logic [7:0]        in_data,
  output logic                   ram_we,
  output logic      [PAY_AW-1:0] ram_waddr,
  output logic      [7:0]        ram_wdata,
  output logic                   ram_re,
  output logic      [PAY_AW-1:0] ram_raddr,
  input  wire logic [7:0]        ram_rdata,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output result_t                out_res
);

  phase_t           phase_r, phase_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [7:0]       accum_r, accum_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_res_r, out_res_nxt;

  logic             slot_free;
  logic             parsing;
  logic             in_acc;
  logic             load;
  result_t          ld_res;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] cnt_inc;
  logic [7:0]       accum_x;

  assign slot_free = !out_valid_r || !out_stall;
  assign parsing   = phase_r inside {PH_HUNT, PH_CMD, PH_LEN, PH_DATA, PH_CHECK};
  assign in_stall  = !parsing || !slot_free;
  assign in_acc    = in_valid && !in_stall;
  assign limit     = (cfg.payload_limit > MAX_PAYLOAD_C) ? MAX_PAYLOAD_C
                                                         : cfg.payload_limit;
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign accum_x   = accum_r ^ in_data;

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    accum_nxt = accum_r;
    load      = 1'b0;
    ld_res    = '0;
    ram_we    = 1'b0;
    ram_waddr = cnt_r[PAY_AW-1:0];
    ram_wdata = in_data;
    ram_re    = 1'b0;
    ram_raddr = idx_r[PAY_AW-1:0];

    if (in_acc && (in_op != OP_BYTE)) begin
      load          = 1'b1;
      ld_res.kind   = KIND_STATUS;
      ld_res.status = line_status(in_op);
      ld_res.last   = 1'b1;
      if (phase_r inside {PH_LEN, PH_DATA, PH_CHECK}) begin
        ld_res.command = cmd_r;
      end
      if (phase_r inside {PH_DATA, PH_CHECK}) begin
        ld_res.frame_length = {2'b00, len_r};
      end
      phase_nxt = PH_HUNT;
      accum_nxt = cfg.check_seed;
    end else begin
      case (phase_r)
        PH_HUNT: begin
          if (in_acc && (in_data == cfg.start_byte)) begin
            accum_nxt = cfg.check_seed ^ in_data;
            cmd_nxt   = '0;
            len_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_CMD;
          end
        end
        PH_CMD: begin
          if (in_acc) begin
            accum_nxt = accum_x;
            cmd_nxt   = in_data;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (in_acc) begin
            accum_nxt = accum_x;
            if (in_data > {2'b00, limit}) begin
              load                = 1'b1;
              ld_res.kind         = KIND_STATUS;
              ld_res.command      = cmd_r;
              ld_res.frame_length = in_data;
              ld_res.status       = ST_LENGTH;
              ld_res.last         = 1'b1;
              phase_nxt           = PH_HUNT;
              accum_nxt           = cfg.check_seed;
            end else begin
              len_nxt   = in_data[CNT_W-1:0];
              cnt_nxt   = '0;
              phase_nxt = (in_data[CNT_W-1:0] == '0) ? PH_CHECK : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (in_acc) begin
            accum_nxt = accum_x;
            ram_we    = (cnt_r < MAX_PAYLOAD_C);
            cnt_nxt   = cnt_inc;
            if (cnt_inc >= len_r) begin
              phase_nxt = PH_CHECK;
            end
          end
        end
        PH_CHECK: begin
          if (in_acc) begin
            if (accum_x != 8'h00) begin
              load                = 1'b1;
              ld_res.kind         = KIND_STATUS;
              ld_res.command      = cmd_r;
              ld_res.frame_length = {2'b00, len_r};
              ld_res.status       = ST_CHECK;
              ld_res.last         = 1'b1;
              phase_nxt           = PH_HUNT;
              accum_nxt           = cfg.check_seed;
            end else begin
              accum_nxt = accum_x;
              idx_nxt   = '0;
              phase_nxt = PH_DRAIN_RD;
            end
          end
        end
        PH_DRAIN_RD: begin
          if (idx_r < len_r) begin
            ram_re    = 1'b1;
            phase_nxt = PH_DRAIN_OUT;
          end else if (slot_free) begin
            load                = 1'b1;
            ld_res.kind         = KIND_STATUS;
            ld_res.command      = cmd_r;
            ld_res.frame_length = {2'b00, len_r};
            ld_res.status       = ST_OK;
            ld_res.last         = 1'b1;
            phase_nxt           = PH_HUNT;
            accum_nxt           = cfg.check_seed;
          end
        end
        PH_DRAIN_OUT: begin
          if (slot_free) begin
            load                = 1'b1;
            ld_res.kind         = KIND_PAYLOAD;
            ld_res.command      = cmd_r;
            ld_res.frame_length = {2'b00, len_r};
            ld_res.position     = idx_r[POS_W-1:0];
            ld_res.payload_byte = ram_rdata;
            ld_res.status       = ST_OK;
            ld_res.last         = 1'b0;
            idx_nxt             = idx_r + CNT_W'(1);
            phase_nxt           = PH_DRAIN_RD;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          accum_nxt = cfg.check_seed;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = ld_res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      cmd_r       <= '0;
      len_r       <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      accum_r     <= CHECK_SEED_RST;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cmd_r       <= cmd_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      accum_r     <= accum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `FCR_ASSERT_IMP(a_store_write_in_frame, ram_we, (phase_r == PH_DATA) && (cnt_r < len_r),
                  "payload store written outside the payload phase")
  `FCR_ASSERT_IMP(a_no_request_in_drain, in_acc,
                  !((phase_r == PH_DRAIN_RD) || (phase_r == PH_DRAIN_OUT)),
                  "request accepted while draining a frame")
  `FCR_ASSERT_IMP(a_last_on_status, out_valid_r, out_res_r.last == out_res_r.kind,
                  "last flag does not match result kind")
  `FCR_ASSERT_IMP(a_read_before_use, phase_r == PH_DRAIN_OUT,
                  ($past(phase_r) == PH_DRAIN_RD) || ($past(phase_r) == PH_DRAIN_OUT),
                  "payload result without a store read")
  `FCR_ASSERT_NXT(a_drain_ends_ok, (phase_r == PH_DRAIN_RD) && (idx_r >= len_r) && slot_free,
                  (phase_r == PH_HUNT) && out_valid_r && (out_res_r.status == ST_OK) &&
                  out_res_r.kind,
                  "drain did not end with an ok status")

endmodule

`default_nettype wire
